// ----- rtl/core/ljp_pkg.sv -----
// Shared types, constants and the pair micro-program of the Lennard-Jones force unit.
// No dependencies; ljp_mul, ljp_datapath, ljp_ctrl and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package ljp_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int POS_W             = 24;
    localparam int BOX_W             = 24;
    localparam int FORCE_W           = 48;
    localparam int INDEX_W           = 6;
    localparam int STEP_W            = 5;
    localparam int PAIR_STEPS        = 22;

    localparam logic [BOX_W-1:0]   BOX_RESET = 24'd655360;
    localparam logic [49:0]        CORE_R    = 50'd67108864;
    localparam logic [63:0]        PAIR_MAX  = 64'd140737488355327;
    localparam logic [63:0]        T_HALF    = 64'd2147483648;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last;
    } in_beat_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        particle_index;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      saturated;
        logic                      last_result;
    } out_beat_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_CLR, OP_RD_POS, OP_CAP_I, OP_CAP_J, OP_DIFF,
        OP_DIV_X, OP_DIV_Y, OP_MUL_X2, OP_MUL_Y2, OP_DIV_R,
        OP_MUL_S2, OP_MUL_S3, OP_MUL_S4, OP_MUL_AX, OP_MUL_AY, OP_MUL_MX, OP_MUL_MY,
        OP_FORCE, OP_RD_ACC, OP_UPD_I, OP_UPD_J, OP_EMIT_CAP
    } dp_op_t;

    typedef enum logic [1:0] {SH_0, SH_16, SH_32, SH_48} sh_sel_t;

    typedef struct packed {
        logic               go;
        dp_op_t             op;
        logic [INDEX_W-1:0] addr;
        logic               last;
    } dp_cmd_t;

    function automatic logic op_is_mul(input dp_op_t op);
        case (op) inside
            OP_MUL_X2, OP_MUL_Y2, OP_MUL_S2, OP_MUL_S3, OP_MUL_S4,
            OP_MUL_AX, OP_MUL_AY, OP_MUL_MX, OP_MUL_MY: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic op_is_div(input dp_op_t op);
        case (op) inside
            OP_DIV_X, OP_DIV_Y, OP_DIV_R: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic op_is_long(input dp_op_t op);
        return op_is_mul(op) | op_is_div(op);
    endfunction

    // One pair evaluation: fetch both positions, wrap, 1/r^2 powers, forces, two updates.
    function automatic dp_op_t pair_op(input logic [STEP_W-1:0] step);
        case (step)
            5'd0:    return OP_RD_POS;
            5'd1:    return OP_CAP_I;
            5'd2:    return OP_RD_POS;
            5'd3:    return OP_CAP_J;
            5'd4:    return OP_DIFF;
            5'd5:    return OP_DIV_X;
            5'd6:    return OP_DIV_Y;
            5'd7:    return OP_MUL_X2;
            5'd8:    return OP_MUL_Y2;
            5'd9:    return OP_DIV_R;
            5'd10:   return OP_MUL_S2;
            5'd11:   return OP_MUL_S3;
            5'd12:   return OP_MUL_S4;
            5'd13:   return OP_MUL_AX;
            5'd14:   return OP_MUL_AY;
            5'd15:   return OP_MUL_MX;
            5'd16:   return OP_MUL_MY;
            5'd17:   return OP_FORCE;
            5'd18:   return OP_RD_ACC;
            5'd19:   return OP_UPD_I;
            5'd20:   return OP_RD_ACC;
            default: return OP_UPD_J;
        endcase
    endfunction

    // The second position read and both steps of the second update address particle j.
    function automatic logic pair_uses_j(input logic [STEP_W-1:0] step);
        return (step == 5'd2) || (step == 5'd20) || (step == 5'd21);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ljp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ljp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ljp_mul.sv -----
// Multi-cycle 64 x 64 multiplier on one 32 x 32 partial-product unit, with a
// right shift and saturation to 64 bits. Depends on ljp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ljp_mul import ljp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        go,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire sh_sel_t     sh,
    output logic [63:0]      res,
    output logic             done
);

    logic [63:0]  a_reg, b_reg;
    sh_sel_t      sh_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pos_reg;
    logic         pv_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [31:0]  a_half, b_half;
    logic         ovf;
    logic [63:0]  sat_val;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        case (sh_reg)
            SH_0: begin
                ovf     = |acc_reg[127:64];
                sat_val = acc_reg[63:0];
            end
            SH_16: begin
                ovf     = |acc_reg[127:80];
                sat_val = acc_reg[79:16];
            end
            SH_32: begin
                ovf     = |acc_reg[127:96];
                sat_val = acc_reg[95:32];
            end
            default: begin
                ovf     = |acc_reg[127:112];
                sat_val = acc_reg[111:48];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
        end else begin
            done <= 1'b0;
            if (go) begin
                a_reg    <= a;
                b_reg    <= b;
                sh_reg   <= sh;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                pv_reg   <= 1'b0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // The product is registered before it joins the running sum.
                if (cnt_reg < 3'd4) begin
                    pp_reg  <= a_half * b_half;
                    pos_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    pv_reg  <= 1'b1;
                end else begin
                    pv_reg <= 1'b0;
                end
                if (pv_reg) begin
                    acc_reg <= acc_reg + ({64'd0, pp_reg} << {pos_reg, 5'd0});
                end
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    res      <= ovf ? '1 : sat_val;
                    done     <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ljp_div.sv -----
// Restoring 64-bit divider, one quotient bit per cycle, giving quotient and remainder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ljp_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        go,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic [63:0]      quot,
    output logic [63:0]      rem,
    output logic             done
);

    logic [63:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] shifted, trial;

    assign shifted = {rem, quot[63]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (go) begin
                quot     <= dividend;
                rem      <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[64]) begin
                    rem  <= trial[63:0];
                    quot <= {quot[62:0], 1'b1};
                end else begin
                    rem  <= shifted[63:0];
                    quot <= {quot[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    done     <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ljp_datapath.sv -----
// Datapath: position and accumulator RAMs, pair arithmetic registers, the shared
// multiplier and divider, and the result register. Depends on ljp_pkg, ljp_ram, ljp_mul, ljp_div.
`timescale 1ns / 1ps
`default_nettype none

module ljp_datapath import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dp_cmd_t          cmd,
    input  wire in_beat_t         s_data,
    input  wire logic [BOX_W-1:0] box_length,
    output logic                  dp_done,
    output out_beat_t             m_data
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int POSW2 = 2 * POS_W;
    localparam int ACC_W = 2 * FORCE_W + 1;

    logic [IDX_W-1:0] addr;
    logic [POSW2-1:0] pos_rd;
    logic [ACC_W-1:0] acc_rd, acc_wdata;
    logic             pos_we, acc_we;

    logic [POSW2-1:0]          pi_reg, pj_reg;
    logic signed [POS_W:0]     dxr_reg, dyr_reg, dx_reg, dy_reg;
    logic [63:0]               rx2_reg, s_reg, s2_reg, s4_reg, ax_a_reg, ay_a_reg, mx_reg, my_reg;
    logic [49:0]               r_reg;
    logic signed [63:0]        t_reg;
    logic signed [FORCE_W-1:0] fx_reg, fy_reg;
    logic                      psat_reg;
    dp_op_t                    pend_reg;
    out_beat_t                 out_reg;

    logic [POS_W:0]  ax, ay, adxr, adyr;
    logic [63:0]     at;
    logic [63:0]     mul_a, mul_b, mul_res, div_a, div_b, div_q, div_r;
    sh_sel_t         mul_sh;
    logic            mul_go, div_go, mul_done, div_done;

    logic signed [FORCE_W-1:0] fx_c, fy_c;
    logic                      sat_c, cx_sat, cy_sat;
    logic [FORCE_W:0]          cx, cy, ux, uy;
    logic signed [FORCE_W-1:0] vx, vy;

    assign addr = cmd.addr[IDX_W-1:0];

    function automatic logic [POS_W:0] mag25(input logic signed [POS_W:0] d);
        return d[POS_W] ? (POS_W + 1)'(-d) : (POS_W + 1)'(d);
    endfunction

    // Nearest image from the remainder of |d| by the box: fold when 2m reaches L.
    function automatic logic signed [POS_W:0] wrap(input logic signed [POS_W:0] d,
                                                   input logic [63:0] rm,
                                                   input logic [BOX_W-1:0] box);
        logic signed [POS_W+1:0] m;
        logic signed [POS_W+1:0] r;
        m = {2'b00, rm[POS_W-1:0]};
        if ({1'b0, rm[POS_W-1:0], 1'b0} < {1'b0, box, 1'b0} - {2'b00, box}) begin
            r = m;
        end else begin
            r = m - $signed({2'b00, box});
        end
        if (box == '0) begin
            return d;
        end
        return d[POS_W] ? (POS_W + 1)'(-r) : (POS_W + 1)'(r);
    endfunction

    // Clipped, signed force component; bit FORCE_W flags clipping.
    function automatic logic [FORCE_W:0] comp(input logic signed [POS_W:0] d,
                                              input logic [63:0] m,
                                              input logic signed [63:0] t);
        logic [FORCE_W-1:0] mg;
        logic               clip;
        clip = m > PAIR_MAX;
        mg   = clip ? PAIR_MAX[FORCE_W-1:0] : m[FORCE_W-1:0];
        if (d == '0 || t == '0) begin
            return '0;
        end
        return {clip, (d[POS_W] != t[63]) ? FORCE_W'(-mg) : mg};
    endfunction

    // Saturating accumulate into [-2^47, 2^47-1]; bit FORCE_W flags clipping.
    function automatic logic [FORCE_W:0] add_sat(input logic signed [FORCE_W-1:0] acc,
                                                 input logic signed [FORCE_W-1:0] v);
        logic signed [FORCE_W:0] s;
        s = {acc[FORCE_W-1], acc} + {v[FORCE_W-1], v};
        if (s[FORCE_W] != s[FORCE_W-1]) begin
            return s[FORCE_W] ? {1'b1, 1'b1, {(FORCE_W-1){1'b0}}}
                              : {1'b1, 1'b0, {(FORCE_W-1){1'b1}}};
        end
        return {1'b0, s[FORCE_W-1:0]};
    endfunction

    assign ax   = mag25(dx_reg);
    assign ay   = mag25(dy_reg);
    assign adxr = mag25(dxr_reg);
    assign adyr = mag25(dyr_reg);
    assign at   = t_reg[63] ? 64'(-t_reg) : 64'(t_reg);

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = SH_0;
        case (cmd.op)
            OP_MUL_X2: begin mul_a = 64'(ax); mul_b = 64'(ax); end
            OP_MUL_Y2: begin mul_a = 64'(ay); mul_b = 64'(ay); end
            OP_MUL_S2: begin mul_a = s_reg;  mul_b = s_reg; mul_sh = SH_32; end
            OP_MUL_S3: begin mul_a = s2_reg; mul_b = s_reg; mul_sh = SH_32; end
            OP_MUL_S4: begin mul_a = s2_reg; mul_b = s2_reg; mul_sh = SH_32; end
            OP_MUL_AX: begin
                mul_a  = (64'(ax) << 5) + (64'(ax) << 4);
                mul_b  = s4_reg;
                mul_sh = SH_16;
            end
            OP_MUL_AY: begin
                mul_a  = (64'(ay) << 5) + (64'(ay) << 4);
                mul_b  = s4_reg;
                mul_sh = SH_16;
            end
            OP_MUL_MX: begin mul_a = ax_a_reg; mul_b = at; mul_sh = SH_48; end
            OP_MUL_MY: begin mul_a = ay_a_reg; mul_b = at; mul_sh = SH_48; end
            default: ;
        endcase
    end

    always_comb begin
        div_a = '1;
        div_b = 64'(r_reg);
        case (cmd.op)
            OP_DIV_X: begin div_a = 64'(adxr); div_b = 64'(box_length); end
            OP_DIV_Y: begin div_a = 64'(adyr); div_b = 64'(box_length); end
            default: ;
        endcase
    end

    assign mul_go  = cmd.go && op_is_mul(cmd.op);
    assign div_go  = cmd.go && op_is_div(cmd.op);
    assign dp_done = mul_done | div_done;

    ljp_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .go(mul_go), .a(mul_a), .b(mul_b), .sh(mul_sh),
        .res(mul_res), .done(mul_done)
    );

    ljp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .go(div_go), .dividend(div_a), .divisor(div_b),
        .quot(div_q), .rem(div_r), .done(div_done)
    );

    // Pair force with the coincident and inner-core cases taking precedence.
    always_comb begin
        cx = comp(dx_reg, mx_reg, t_reg);
        cy = comp(dy_reg, my_reg, t_reg);
        cx_sat = cx[FORCE_W];
        cy_sat = cy[FORCE_W];
        if (r_reg == '0) begin
            fx_c  = '0;
            fy_c  = '0;
            sat_c = 1'b1;
        end else if (r_reg < CORE_R) begin
            fx_c  = (dx_reg == '0) ? '0 : (dx_reg[POS_W] ? -$signed(PAIR_MAX[FORCE_W-1:0])
                                                        : $signed(PAIR_MAX[FORCE_W-1:0]));
            fy_c  = (dy_reg == '0) ? '0 : (dy_reg[POS_W] ? -$signed(PAIR_MAX[FORCE_W-1:0])
                                                        : $signed(PAIR_MAX[FORCE_W-1:0]));
            sat_c = 1'b1;
        end else begin
            fx_c  = cx[FORCE_W-1:0];
            fy_c  = cy[FORCE_W-1:0];
            sat_c = cx_sat | cy_sat;
        end
    end

    assign vx = (cmd.op == OP_UPD_J) ? -fx_reg : fx_reg;
    assign vy = (cmd.op == OP_UPD_J) ? -fy_reg : fy_reg;
    assign ux = add_sat(acc_rd[ACC_W-1 -: FORCE_W], vx);
    assign uy = add_sat(acc_rd[FORCE_W:1], vy);

    assign pos_we    = cmd.go && (cmd.op == OP_LOAD);
    assign acc_we    = cmd.go && (cmd.op == OP_CLR || cmd.op == OP_UPD_I || cmd.op == OP_UPD_J);
    assign acc_wdata = (cmd.op == OP_CLR) ? '0 :
                       {ux[FORCE_W-1:0], uy[FORCE_W-1:0],
                        acc_rd[0] | psat_reg | ux[FORCE_W] | uy[FORCE_W]};

    ljp_ram #(.WIDTH(POSW2), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .aclk(aclk), .we(pos_we), .waddr(addr), .wdata({s_data.pos_x, s_data.pos_y}),
        .raddr(addr), .rdata(pos_rd)
    );

    ljp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_PARTICLES)) u_acc_ram (
        .aclk(aclk), .we(acc_we), .waddr(addr), .wdata(acc_wdata),
        .raddr(addr), .rdata(acc_rd)
    );

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            case (cmd.op)
                OP_CAP_I: pi_reg <= pos_rd;
                OP_CAP_J: pj_reg <= pos_rd;
                OP_DIFF: begin
                    dxr_reg <= $signed({1'b0, pi_reg[POSW2-1:POS_W]})
                             - $signed({1'b0, pj_reg[POSW2-1:POS_W]});
                    dyr_reg <= $signed({1'b0, pi_reg[POS_W-1:0]})
                             - $signed({1'b0, pj_reg[POS_W-1:0]});
                end
                OP_FORCE: begin
                    fx_reg   <= fx_c;
                    fy_reg   <= fy_c;
                    psat_reg <= sat_c;
                end
                OP_EMIT_CAP: begin
                    out_reg.particle_index <= INDEX_W'(addr);
                    out_reg.force_x        <= acc_rd[ACC_W-1 -: FORCE_W];
                    out_reg.force_y        <= acc_rd[FORCE_W:1];
                    out_reg.saturated      <= acc_rd[0];
                    out_reg.last_result    <= cmd.last;
                end
                default: ;
            endcase
            if (op_is_long(cmd.op)) begin
                pend_reg <= cmd.op;
            end
        end
        if (mul_done) begin
            case (pend_reg)
                OP_MUL_X2: rx2_reg  <= mul_res;
                OP_MUL_Y2: r_reg    <= 50'(rx2_reg + mul_res);
                OP_MUL_S2: s2_reg   <= mul_res;
                OP_MUL_S3: t_reg    <= $signed(mul_res - T_HALF);
                OP_MUL_S4: s4_reg   <= mul_res;
                OP_MUL_AX: ax_a_reg <= mul_res;
                OP_MUL_AY: ay_a_reg <= mul_res;
                OP_MUL_MX: mx_reg   <= mul_res;
                OP_MUL_MY: my_reg   <= mul_res;
                default: ;
            endcase
        end
        if (div_done) begin
            case (pend_reg)
                OP_DIV_X: dx_reg <= wrap(dxr_reg, div_r, box_length);
                OP_DIV_Y: dy_reg <= wrap(dyr_reg, div_r, box_length);
                // All-ones over r rounds up when the remainder is r - 1.
                OP_DIV_R: s_reg  <= div_q + 64'(div_r == 64'(r_reg) - 64'd1);
                default: ;
            endcase
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ljp_ctrl.sv -----
// Controller: load counting, accumulator clearing sweep, pair loop sequencing and
// result emission. Depends on ljp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ljp_ctrl import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_last,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire logic dp_done,
    output dp_cmd_t   cmd
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [2:0] {
        ST_LOAD, ST_CLEAR, ST_PAIR, ST_WAIT, ST_EMIT_RD, ST_EMIT_CAP, ST_EMIT_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ld_reg, ld_next, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CNT_W-1:0]  n_reg, n_next, n_m1, n_m2;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              adv;
    dp_op_t            cur_op;

    assign n_m1    = n_reg - CNT_W'(1);
    assign n_m2    = n_reg - CNT_W'(2);
    assign cur_op  = pair_op(step_reg);
    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        ld_next      = ld_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        adv          = 1'b0;
        cmd          = '0;
        cmd.op       = OP_NOP;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.go   = s_valid;
                cmd.op   = OP_LOAD;
                cmd.addr = INDEX_W'(ld_reg);
                if (s_valid) begin
                    // A full store starts the run as a marked beat does.
                    if (s_last || ld_reg == IDX_W'(MAX_PARTICLES - 1)) begin
                        n_next     = CNT_W'(ld_reg) + CNT_W'(1);
                        ld_next    = '0;
                        k_next     = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        ld_next = ld_reg + IDX_W'(1);
                    end
                end
            end
            ST_CLEAR: begin
                cmd.go   = 1'b1;
                cmd.op   = OP_CLR;
                cmd.addr = INDEX_W'(k_reg);
                if (CNT_W'(k_reg) == n_m1) begin
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = IDX_W'(1);
                    step_next  = '0;
                    state_next = (n_reg == CNT_W'(1)) ? ST_EMIT_RD : ST_PAIR;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_PAIR: begin
                cmd.go   = 1'b1;
                cmd.op   = cur_op;
                cmd.addr = INDEX_W'(pair_uses_j(step_reg) ? j_reg : i_reg);
                if (op_is_long(cur_op)) begin
                    state_next = ST_WAIT;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_WAIT: begin
                if (dp_done) begin
                    adv        = 1'b1;
                    state_next = ST_PAIR;
                end
            end
            ST_EMIT_RD: begin
                cmd.go     = 1'b1;
                cmd.op     = OP_RD_ACC;
                cmd.addr   = INDEX_W'(k_reg);
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP: begin
                cmd.go       = 1'b1;
                cmd.op       = OP_EMIT_CAP;
                cmd.addr     = INDEX_W'(k_reg);
                cmd.last     = (CNT_W'(k_reg) == n_m1);
                m_valid_next = 1'b1;
                state_next   = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (CNT_W'(k_reg) == n_m1) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
        if (adv) begin
            if (step_reg == STEP_W'(PAIR_STEPS - 1)) begin
                step_next = '0;
                if (CNT_W'(j_reg) == n_m1) begin
                    if (CNT_W'(i_reg) == n_m2) begin
                        k_next     = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        i_next = i_reg + IDX_W'(1);
                        j_next = i_reg + IDX_W'(2);
                    end
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            ld_reg      <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ld_reg      <= ld_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lennard_jones_pair_forces_unit.sv -----
// Lennard-Jones pair force unit, 2-D periodic box. Loading accepts one beat per cycle.
// A run over n particles first clears the n accumulators, then evaluates the n(n-1)/2
// pairs, each with three 64-bit divider passes and nine multiplications on the shared
// 32x32 multiplier. Each result is then read from its accumulator, captured and held
// on the output until taken. Synchronous active-low reset clears control
// and sets box_length to 10.0; the per-run clearing sweep resets the accumulators.
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_pair_forces_unit import ljp_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [BOX_W-1:0] box_reg;
    logic             dp_done;
    dp_cmd_t          cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {8'd0, box_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= BOX_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            box_reg <= pwdata[BOX_W-1:0];
        end
    end

    ljp_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_last(s_data.last),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready), .dp_done(dp_done),
        .cmd(cmd)
    );

    ljp_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_datapath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .s_data(s_data),
        .box_length(box_reg), .dp_done(dp_done), .m_data(m_data)
    );

endmodule

`default_nettype wire
